FILE: rtl/core/lgfs_pkg.sv
package lgfs_pkg;

    localparam int NUM_CHANNELS = 24;
    localparam int CH_W         = 5;   // index width for the channel store
    localparam int LEVEL_W      = 8;
    localparam int WORD_W       = 12;
    localparam int SHIFT_W      = 4;
    localparam int BIT_W        = 4;   // counts the bits of one word

    localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(NUM_CHANNELS - 1);
    localparam logic [CH_W-1:0]  MAX_CNT  = CH_W'(NUM_CHANNELS);
    localparam logic [BIT_W-1:0] TOP_BIT  = BIT_W'(WORD_W - 1);

    typedef enum logic [1:0] {
        OP_SET     = 2'd0,
        OP_FILL    = 2'd1,
        OP_SCALED  = 2'd2,
        OP_ROTATED = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        LATCH_NONE  = 2'd0,
        LATCH_BLANK = 2'd1,
        LATCH_RAISE = 2'd2
    } t_latch;

    // controller to datapath
    typedef struct packed {
        logic set_ch;
        logic fill;
        logic capture;
        logic mod_step;
        logic load;
        logic shift;
        logic emit_word;
        logic emit_empty;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic off_ge_cnt;
        logic bit_zero;
        logic is_last;
    } t_status;

endpackage

FILE: rtl/core/lgfs_ctrl.sv
module lgfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_opcode,
    input  lgfs_pkg::t_status i_status,
    output lgfs_pkg::t_cmd    o_cmd,
    output logic              busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_LOAD,
        S_SHIFT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    assign busy = r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (start && !r_busy) begin
                    unique case (lgfs_pkg::t_opcode'(i_opcode))
                        lgfs_pkg::OP_SET:  o_cmd.set_ch = 1'b1;
                        lgfs_pkg::OP_FILL: o_cmd.fill = 1'b1;
                        lgfs_pkg::OP_SCALED, lgfs_pkg::OP_ROTATED: begin
                            o_cmd.capture = 1'b1;
                            n_state       = S_MOD;
                            n_busy        = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                // reduce the start offset by repeated subtraction
                priority if (i_status.cnt_zero) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = S_IDLE;
                    n_busy           = 1'b0;
                end else if (i_status.off_ge_cnt) begin
                    o_cmd.mod_step = 1'b1;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SHIFT;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                if (!i_status.bit_zero) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    o_cmd.emit_word = 1'b1;
                    if (i_status.is_last) begin
                        n_state = S_IDLE;
                        n_busy  = 1'b0;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

endmodule

FILE: rtl/core/lgfs_datapath.sv
module lgfs_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lgfs_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [lgfs_pkg::SHIFT_W-1:0]        i_cfg_wdata,
    input  logic [1:0]                          i_opcode,
    input  logic [lgfs_pkg::CH_W-1:0]           i_channel_index,
    input  logic [lgfs_pkg::LEVEL_W-1:0]        i_level,
    input  logic [lgfs_pkg::CH_W-1:0]           i_send_count,
    input  logic [lgfs_pkg::CH_W-1:0]           i_start_offset,
    output lgfs_pkg::t_status                   o_status,
    output logic                                o_result_strobe,
    output logic [lgfs_pkg::WORD_W-1:0]         o_gray_word,
    output logic                                o_word_valid,
    output logic                                o_last,
    output logic [1:0]                          o_latch_action
);

    logic [lgfs_pkg::LEVEL_W-1:0] r_store [lgfs_pkg::NUM_CHANNELS];
    logic [lgfs_pkg::SHIFT_W-1:0] r_bright;
    logic                         r_rotated;
    logic [lgfs_pkg::CH_W-1:0]    r_cnt;
    logic [lgfs_pkg::CH_W-1:0]    r_ch;
    logic [lgfs_pkg::CH_W-1:0]    r_idx;
    logic [lgfs_pkg::BIT_W-1:0]   r_bit;
    logic [lgfs_pkg::WORD_W-1:0]  r_word;

    logic                         r_strobe;
    logic [lgfs_pkg::WORD_W-1:0]  r_out_word;
    logic                         r_out_valid;
    logic                         r_out_last;
    logic [1:0]                   r_out_latch;

    logic [lgfs_pkg::CH_W-1:0]    n_cnt;
    logic [lgfs_pkg::WORD_W-1:0]  n_word;
    logic [lgfs_pkg::WORD_W-1:0]  raw_word;
    logic [lgfs_pkg::CH_W-1:0]    n_ch;
    logic [1:0]                   frame_latch;

    assign n_cnt = (i_send_count > lgfs_pkg::MAX_CNT) ? lgfs_pkg::MAX_CNT : i_send_count;

    assign raw_word = {r_store[r_ch], 4'b0000};
    // shifts of 12 or more clear every bit of a 12-bit word
    assign n_word   = r_rotated ? raw_word : (raw_word >> r_bright);

    // wrap the rotated read pointer at the frame count
    assign n_ch = (r_ch + 1'b1 == r_cnt) ? '0 : r_ch + 1'b1;

    assign frame_latch = r_rotated ? lgfs_pkg::LATCH_RAISE : lgfs_pkg::LATCH_BLANK;

    assign o_status.cnt_zero   = (r_cnt == '0);
    assign o_status.off_ge_cnt = (r_ch >= r_cnt);
    assign o_status.bit_zero   = (r_bit == '0);
    assign o_status.is_last    = (r_idx == r_cnt - 1'b1);

    assign o_result_strobe = r_strobe;
    assign o_gray_word     = r_out_word;
    assign o_word_valid    = r_out_valid;
    assign o_last          = r_out_last;
    assign o_latch_action  = r_out_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lgfs_pkg::NUM_CHANNELS; i++) begin
                r_store[i] <= '0;
            end
            r_bright <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_bright <= i_cfg_wdata;
            end
            if (i_cmd.set_ch && (i_channel_index <= lgfs_pkg::LAST_CH)) begin
                r_store[i_channel_index] <= i_level;
            end
            if (i_cmd.fill) begin
                for (int i = 0; i < lgfs_pkg::NUM_CHANNELS; i++) begin
                    r_store[i] <= i_level;
                end
            end
            if (i_cmd.emit_word || i_cmd.emit_empty) begin
                r_strobe <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rotated <= (lgfs_pkg::t_opcode'(i_opcode) == lgfs_pkg::OP_ROTATED);
            r_cnt     <= n_cnt;
            r_ch      <= (lgfs_pkg::t_opcode'(i_opcode) == lgfs_pkg::OP_ROTATED)
                         ? i_start_offset : '0;
            r_idx     <= '0;
        end
        if (i_cmd.mod_step) begin
            r_ch <= r_ch - r_cnt;
        end
        if (i_cmd.load) begin
            r_word <= n_word;
            r_bit  <= lgfs_pkg::TOP_BIT;
        end
        if (i_cmd.shift) begin
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.emit_word) begin
            r_out_word  <= r_word;
            r_out_valid <= 1'b1;
            r_out_last  <= o_status.is_last;
            r_out_latch <= o_status.is_last ? frame_latch : lgfs_pkg::LATCH_NONE;
            r_idx       <= r_idx + 1'b1;
            r_ch        <= n_ch;
        end
        if (i_cmd.emit_empty) begin
            r_out_word  <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b1;
            r_out_latch <= frame_latch;
        end
    end

endmodule

FILE: rtl/core/led_grayscale_frame_shifter.sv
// channel   ports                                   handshake
// command   i_opcode i_channel_index i_level        start & !busy
//           i_send_count i_start_offset
// config    i_cfg_wdata                             i_cfg_we
// result    o_gray_word o_word_valid o_last         o_result_strobe, one cycle
//           o_latch_action
//
// set and fill items leave busy low.
// a frame item first reduces the offset by repeated subtraction (at most 31 subtractions),
// then gives each word one load and its bit clocks; an empty frame returns from the reduce state.
// the bit clock counter in the datapath sets the word rate.
// reset is synchronous, active low, and clears the channel store and the brightness.
// the receiver cannot stall: each result shows for one cycle with the strobe.
module led_grayscale_frame_shifter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [lgfs_pkg::CH_W-1:0]     i_channel_index,
    input  logic [lgfs_pkg::LEVEL_W-1:0]  i_level,
    input  logic [lgfs_pkg::CH_W-1:0]     i_send_count,
    input  logic [lgfs_pkg::CH_W-1:0]     i_start_offset,
    input  logic                          i_cfg_we,
    input  logic [lgfs_pkg::SHIFT_W-1:0]  i_cfg_wdata,
    output logic                          o_result_strobe,
    output logic [lgfs_pkg::WORD_W-1:0]   o_gray_word,
    output logic                          o_word_valid,
    output logic                          o_last,
    output logic [1:0]                    o_latch_action
);

    lgfs_pkg::t_cmd    cmd;
    lgfs_pkg::t_status status;

    lgfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    lgfs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_channel_index (i_channel_index),
        .i_level         (i_level),
        .i_send_count    (i_send_count),
        .i_start_offset  (i_start_offset),
        .o_status        (status),
        .o_result_strobe (o_result_strobe),
        .o_gray_word     (o_gray_word),
        .o_word_valid    (o_word_valid),
        .o_last          (o_last),
        .o_latch_action  (o_latch_action)
    );

endmodule
